[hw/rtl/debug_break_match_unit_macros.svh]
// ---------------------------------------------------------------------------
// Debug break match unit assertion macros
// Concurrent assertion shorthands on clk_i and rst_ni, empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef DEBUG_BREAK_MATCH_UNIT_MACROS_SVH
`define DEBUG_BREAK_MATCH_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define DBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DBM_ASSERT_NOW(label, ante, cons, msg)
`define DBM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[hw/rtl/dbm_pkg.sv]
// ---------------------------------------------------------------------------
// Debug break match package
// Request codes, payload types and the beat that walks the cell chains.
// ---------------------------------------------------------------------------
package dbm_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned REG_ID_W = 4;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned VAL_W    = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_REG_WR  = 3'd0,
    REQ_MEM_WR  = 3'd1,
    REQ_POLL    = 3'd2,
    REQ_ADD_REG = 3'd3,
    REQ_DEL_REG = 3'd4,
    REQ_ADD_MEM = 3'd5,
    REQ_DEL_MEM = 3'd6,
    REQ_CLEAR   = 3'd7
  } req_e;

  // Operation carried by a beat through a chain of entry cells.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_HIT,
    OP_PROBE,
    OP_PUT_MATCH,
    OP_PUT_FREE,
    OP_DROP_KV,
    OP_DROP_K,
    OP_WIPE
  } cell_op_e;

  typedef struct packed {
    req_e                  req_type;
    logic [REG_ID_W-1:0]   reg_id;
    logic [ADDR_W-1:0]     address;
    logic [VAL_W-1:0]      value;
    logic                  match_any;
  } req_t;

  typedef struct packed {
    logic break_seen;
    logic status;
  } rsp_t;

  typedef struct packed {
    logic              valid;
    cell_op_e          op;
    logic [ADDR_W-1:0] key;
    logic [VAL_W-1:0]  value;
    logic              any;
    logic              hit;
    logic              claimed;
  } beat_t;

endpackage

[hw/rtl/dbm_if.sv]
// ---------------------------------------------------------------------------
// Debug break match stream interfaces
// Valid/ready channels for requests and responses.
// ---------------------------------------------------------------------------
interface dbm_req_if;
  import dbm_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dbm_rsp_if;
  import dbm_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/debug_break_match_unit.sv]
// ---------------------------------------------------------------------------
// Debug break match unit
// Register breakpoints and memory watchpoints with a sticky break flag.
// ---------------------------------------------------------------------------
// Requests arrive on req_i and each gives exactly one response on rsp_o, both
// valid/ready channels; a beat moves when valid and ready are high together.
// Breakpoints sit in two rows of entry cells, one per store. A request is
// turned into a beat that walks each row one cell per cycle; the response is
// registered once both rows have been walked, and the next request is taken
// only once that response is registered. A memory add walks the watchpoint
// row twice, first to find an entry at the same address and then to write.
// One request is handled at a time; req_i.ready is high only while the unit
// is idle.
// The response sits in an output register, so a new request is taken while an
// earlier response waits; a stalled receiver holds the next response back
// until the register frees, and the unit then stops taking requests.
// Reset empties both stores, clears the break flag and drops any response.
// ---------------------------------------------------------------------------
`include "debug_break_match_unit_macros.svh"

module debug_break_match_unit #(
  parameter int unsigned REG_BREAK_SLOTS = 16,
  parameter int unsigned MEM_BREAK_SLOTS = 8,
  parameter int unsigned REG_COUNT       = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dbm_req_if.sink       req_i,
  dbm_rsp_if.source     rsp_o
);
  import dbm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q, state_d;
  req_t   req_q, req_d;
  beat_t  rlaunch_q, rlaunch_d;
  beat_t  mlaunch_q, mlaunch_d;
  logic   rdone_q, rdone_d, mdone_q, mdone_d;
  logic   rhit_q, rhit_d, mhit_q, mhit_d;
  logic   rclaim_q, rclaim_d, mclaim_q, mclaim_d;
  logic   phase_q, phase_d;
  logic   pending_q, pending_d;
  logic   out_valid_q, out_valid_d;
  rsp_t   rsp_q, rsp_d;

  beat_t  reg_beat [REG_BREAK_SLOTS+1];
  beat_t  mem_beat [MEM_BREAK_SLOTS+1];
  beat_t  reg_end, mem_end;

  logic   req_fire;
  logic   reg_ok;
  logic   finish;
  logic   seen_now;
  logic   add_req;
  logic   poll_req;

  assign reg_beat[0] = rlaunch_q;
  assign mem_beat[0] = mlaunch_q;
  assign reg_end     = reg_beat[REG_BREAK_SLOTS];
  assign mem_end     = mem_beat[MEM_BREAK_SLOTS];

  for (genvar i = 0; i < REG_BREAK_SLOTS; i++) begin : g_reg_cell
    dbm_cell #(.KEY_W(REG_ID_W)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .beat_i(reg_beat[i]),
      .beat_o(reg_beat[i+1])
    );
  end

  for (genvar i = 0; i < MEM_BREAK_SLOTS; i++) begin : g_mem_cell
    dbm_cell #(.KEY_W(ADDR_W)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .beat_i(mem_beat[i]),
      .beat_o(mem_beat[i+1])
    );
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign reg_ok      = int'(req_i.data.reg_id) < int'(REG_COUNT);
  assign finish      = (state_q == ST_RUN) && rdone_q && mdone_q &&
                       (!out_valid_q || rsp_o.ready);
  assign seen_now    = pending_q | rhit_q | mhit_q;
  assign add_req     = (req_q.req_type == REQ_ADD_REG) || (req_q.req_type == REQ_ADD_MEM);
  assign poll_req    = (req_q.req_type == REQ_POLL);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    rlaunch_d   = '0;
    mlaunch_d   = '0;
    rdone_d     = rdone_q;
    mdone_d     = mdone_q;
    rhit_d      = rhit_q;
    mhit_d      = mhit_q;
    rclaim_d    = rclaim_q;
    mclaim_d    = mclaim_q;
    phase_d     = phase_q;
    pending_d   = pending_q;
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;

    if (rsp_o.valid && rsp_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          req_d   = req_i.data;
          rdone_d = 1'b0;
          mdone_d = 1'b0;
          phase_d = 1'b0;
          state_d = ST_RUN;

          // Only a free-slot search starts unclaimed, so a full row shows up
          // as a beat that leaves the row still unclaimed.
          rlaunch_d.valid   = 1'b1;
          rlaunch_d.key     = ADDR_W'(req_i.data.reg_id);
          rlaunch_d.value   = req_i.data.value;
          rlaunch_d.claimed = 1'b1;
          case (req_i.data.req_type)
            REQ_REG_WR: rlaunch_d.op = reg_ok ? OP_HIT : OP_NOP;
            REQ_ADD_REG: begin
              rlaunch_d.op      = reg_ok ? OP_PUT_FREE : OP_NOP;
              rlaunch_d.claimed = !reg_ok;
            end
            REQ_DEL_REG: rlaunch_d.op = OP_DROP_KV;
            REQ_CLEAR:   rlaunch_d.op = OP_WIPE;
            default:     rlaunch_d.op = OP_NOP;
          endcase

          mlaunch_d.valid   = 1'b1;
          mlaunch_d.key     = req_i.data.address;
          mlaunch_d.value   = req_i.data.value;
          mlaunch_d.any     = req_i.data.match_any;
          mlaunch_d.claimed = 1'b1;
          case (req_i.data.req_type)
            REQ_MEM_WR:  mlaunch_d.op = OP_HIT;
            REQ_ADD_MEM: mlaunch_d.op = OP_PROBE;
            REQ_DEL_MEM: mlaunch_d.op = OP_DROP_K;
            REQ_CLEAR:   mlaunch_d.op = OP_WIPE;
            default:     mlaunch_d.op = OP_NOP;
          endcase
        end
      end
      ST_RUN: begin
        if (reg_end.valid) begin
          rdone_d  = 1'b1;
          rhit_d   = reg_end.hit;
          rclaim_d = reg_end.claimed;
        end
        if (mem_end.valid) begin
          if (!phase_q && (req_q.req_type == REQ_ADD_MEM)) begin
            // Second walk: overwrite the entry at this address if the probe
            // found one, otherwise take the lowest free slot.
            phase_d           = 1'b1;
            mlaunch_d.valid   = 1'b1;
            mlaunch_d.op      = mem_end.hit ? OP_PUT_MATCH : OP_PUT_FREE;
            mlaunch_d.key     = req_q.address;
            mlaunch_d.value   = req_q.value;
            mlaunch_d.any     = req_q.match_any;
            mlaunch_d.claimed = mem_end.hit;
          end else begin
            mdone_d  = 1'b1;
            mhit_d   = mem_end.hit;
            mclaim_d = mem_end.claimed;
          end
        end
        if (finish) begin
          out_valid_d      = 1'b1;
          rsp_d.status     = !(rclaim_q && mclaim_q);
          if (req_q.req_type == REQ_POLL) begin
            rsp_d.break_seen = pending_q;
            pending_d        = 1'b0;
          end else begin
            rsp_d.break_seen = seen_now;
            pending_d        = seen_now;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= '0;
      rlaunch_q   <= '0;
      mlaunch_q   <= '0;
      rdone_q     <= 1'b0;
      mdone_q     <= 1'b0;
      rhit_q      <= 1'b0;
      mhit_q      <= 1'b0;
      rclaim_q    <= 1'b0;
      mclaim_q    <= 1'b0;
      phase_q     <= 1'b0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      rlaunch_q   <= rlaunch_d;
      mlaunch_q   <= mlaunch_d;
      rdone_q     <= rdone_d;
      mdone_q     <= mdone_d;
      rhit_q      <= rhit_d;
      mhit_q      <= mhit_d;
      rclaim_q    <= rclaim_d;
      mclaim_q    <= mclaim_d;
      phase_q     <= phase_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = rsp_q;

  `DBM_ASSERT_NOW(a_reg_end, reg_end.valid, (state_q == ST_RUN) && !rdone_q, "stray reg beat")
  `DBM_ASSERT_NOW(a_mem_end, mem_end.valid, (state_q == ST_RUN) && !mdone_q, "stray mem beat")
  `DBM_ASSERT_NOW(a_drop_add, finish && !(rclaim_q && mclaim_q), add_req, "drop without add")
  `DBM_ASSERT_NEXT(a_poll_clr, finish && poll_req, !pending_q && rsp_o.valid, "poll kept flag")

endmodule

[hw/rtl/dbm_cell.sv]
// ---------------------------------------------------------------------------
// Debug break match entry cell
// Holds one breakpoint entry, acts on the passing beat and forwards it.
// ---------------------------------------------------------------------------
module dbm_cell #(
  parameter int unsigned KEY_W = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dbm_pkg::beat_t beat_i,
  output dbm_pkg::beat_t beat_o
);
  import dbm_pkg::*;

  logic             valid_q, valid_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic             any_q, any_d;
  beat_t            beat_q, beat_d;
  logic             key_hit;
  logic             val_hit;
  logic             do_put;

  assign key_hit = valid_q && (key_q == beat_i.key[KEY_W-1:0]);
  assign val_hit = (val_q == beat_i.value);

  always_comb begin
    valid_d = valid_q;
    beat_d  = beat_i;
    do_put  = 1'b0;
    if (beat_i.valid) begin
      case (beat_i.op)
        OP_HIT:       beat_d.hit = beat_i.hit | (key_hit & (any_q | val_hit));
        OP_PROBE:     beat_d.hit = beat_i.hit | key_hit;
        OP_PUT_MATCH: do_put = key_hit;
        OP_PUT_FREE: begin
          // The first free cell along the chain takes the entry.
          do_put         = !valid_q && !beat_i.claimed;
          beat_d.claimed = beat_i.claimed | !valid_q;
        end
        OP_DROP_KV: begin
          if (key_hit && val_hit) valid_d = 1'b0;
        end
        OP_DROP_K: begin
          if (key_hit) valid_d = 1'b0;
        end
        OP_WIPE:      valid_d = 1'b0;
        default:      ;
      endcase
    end
    if (do_put) valid_d = 1'b1;
    key_d = do_put ? beat_i.key[KEY_W-1:0] : key_q;
    val_d = do_put ? (beat_i.any ? '0 : beat_i.value) : val_q;
    any_d = do_put ? beat_i.any : any_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= '0;
    end else begin
      valid_q <= valid_d;
      beat_q  <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
    any_q <= any_d;
  end

  assign beat_o = beat_q;

endmodule
